FILE: hdl/assert_macros.svh
// assertion macros used by the fir lowpass rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define FIRLP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("firlp assertion failed");

// same-cycle implication
`define FIRLP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("firlp implication failed");

// next-cycle implication
`define FIRLP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("firlp next-cycle check failed");

`else

`define FIRLP_ASSERT(lbl, clk, rst, prop)
`define FIRLP_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define FIRLP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/firlp_pkg.sv
// shared constants and coefficient function for the fir lowpass
// no dependencies
`default_nettype none

package firlp_pkg;

   localparam int SAMPLE_W  = 12;
   localparam int TABLE_LEN = 30;
   localparam longint unsigned MICRO_DEN  = 64'd1000000;
   localparam longint unsigned MICRO_HALF = 64'd500000;

   // symmetric lowpass coefficients in millionths
   localparam int unsigned COEF_MICRO [TABLE_LEN] = '{
      18158, 18585, 18986, 19361, 19709, 20028, 20318, 20578,
      20807, 21005, 21170, 21304, 21404, 21471, 21504,
      21504, 21471, 21404, 21304, 21170, 21005, 20807, 20578,
      20318, 20028, 19709, 19361, 18986, 18585, 18158
   };

   localparam logic [SAMPLE_W-1:0] OUT_MAX = {SAMPLE_W{1'b1}};

   // round(c * 2^frac), ties up; taps beyond the table get zero
   function automatic longint unsigned firlp_coef(input int k, input int frac);
      longint unsigned m;
      m = 64'd0;
      if (k >= 0 && k < TABLE_LEN) begin
         m = longint'(COEF_MICRO[k]);
         m = ((m << frac) + MICRO_HALF) / MICRO_DEN;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/firlp_cell.sv
// one tap cell of the transposed fir chain: multiply-add and partial sum register
// depends on firlp_pkg
`default_nettype none

module firlp_cell
   import firlp_pkg::*;
#(
   parameter int COEF_W = 12,
   parameter int ACC_W  = 34,
   parameter logic [COEF_W-1:0] COEF = '0
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 advance,
   input  wire  [SAMPLE_W-1:0] sample,
   input  wire  [ACC_W-1:0]    part_i,
   output logic [ACC_W-1:0]    part_o
);

   logic [SAMPLE_W+COEF_W-1:0] prod;
   logic [ACC_W-1:0]           part_ff;
   logic [ACC_W-1:0]           part_in;

   assign prod    = (SAMPLE_W+COEF_W)'(sample) * (SAMPLE_W+COEF_W)'(COEF);
   assign part_in = ACC_W'(prod) + part_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= '0;
      end else if (advance) begin
         part_ff <= part_in;
      end
   end

   assign part_o = part_ff;

endmodule

`default_nettype wire

FILE: hdl/firlp_out.sv
// tap zero multiply-add, truncation and saturation, two-entry output buffer
// depends on firlp_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module firlp_out
   import firlp_pkg::*;
#(
   parameter int COEF_W         = 12,
   parameter int ACC_W          = 34,
   parameter int COEF_FRAC_BITS = 16,
   parameter logic [COEF_W-1:0] COEF = '0
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_stall,
   output logic                advance,
   input  wire  [SAMPLE_W-1:0] sample,
   input  wire  [ACC_W-1:0]    part_i,
   output logic                out_valid,
   input  wire                 out_stall,
   output logic [SAMPLE_W-1:0] out_data
);

   localparam int TOP_LO = COEF_FRAC_BITS + SAMPLE_W;

   logic [SAMPLE_W+COEF_W-1:0] prod;
   logic [ACC_W-1:0]           acc;
   logic [SAMPLE_W-1:0]        result;

   logic                main_valid_ff, main_valid_in;
   logic [SAMPLE_W-1:0] main_data_ff,  main_data_in;
   logic                skid_valid_ff, skid_valid_in;
   logic [SAMPLE_W-1:0] skid_data_ff,  skid_data_in;
   logic                take_out;
   logic                main_free;

   assign prod = (SAMPLE_W+COEF_W)'(sample) * (SAMPLE_W+COEF_W)'(COEF);
   assign acc  = ACC_W'(prod) + part_i;

   // truncate the fraction, clamp anything above the 12-bit range
   always_comb begin
      if (acc[ACC_W-1:TOP_LO] != '0) begin
         result = OUT_MAX;
      end else begin
         result = acc[TOP_LO-1:COEF_FRAC_BITS];
      end
   end

   assign take_out  = main_valid_ff && !out_stall;
   assign main_free = !main_valid_ff || take_out;
   assign in_stall  = skid_valid_ff;
   assign advance   = in_valid && !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         priority if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (advance) begin
            main_valid_in = 1'b1;
            main_data_in  = result;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (advance) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   `FIRLP_ASSERT_IMPL(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff)
   `FIRLP_ASSERT_NEXT(a_accept_lands, clock, reset, advance, main_valid_ff)
   `FIRLP_ASSERT_NEXT(a_skid_kept, clock, reset, skid_valid_ff && out_stall, skid_valid_ff)
   `FIRLP_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && !out_stall, !skid_valid_ff && main_valid_ff)

endmodule

`default_nettype wire

FILE: hdl/fir_lowpass_30tap.sv
// fir_lowpass_30tap: 30-tap symmetric fir lowpass for a 12-bit sample stream.
// The filter is built in transposed form as a row of tap cells: every accepted
// item is broadcast to all cells, each cell multiplies it by its own fixed
// coefficient and adds the partial sum handed over by its right neighbor, then
// registers the result for its left neighbor. The leftmost tap (coefficient 0)
// sits in the output stage, which forms the full sum, drops the 16 fraction
// bits and clamps at 4095. One item is accepted every clock cycle while
// req_stall is low; the result is registered in the output buffer for rsp_.
// The rate is set by the single 12 x coefficient multiply-add in each cell
// and in the output stage. A two-entry output buffer lets a new item enter
// while a result still waits; req_stall rises only once both entries are
// full. Reset clears all partial sums, i.e. an all-zero sample history.
// depends on firlp_pkg, firlp_cell, firlp_out
`default_nettype none

module fir_lowpass_30tap
   import firlp_pkg::*;
#(
   parameter int TAPS           = 30,
   parameter int COEF_FRAC_BITS = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   // input item channel
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [SAMPLE_W-1:0] req_sample,
   // result item channel
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [SAMPLE_W-1:0] rsp_filtered
);

   // coefficients stay below 1/32, so frac-4 bits hold any of them
   localparam int COEF_W = COEF_FRAC_BITS - 4;
   // full precision sum plus headroom for saturation detection
   localparam int ACC_W  = COEF_FRAC_BITS + SAMPLE_W + 1 + $clog2(TAPS);

   logic             advance;
   // partial sum chain, entry k is the output of the cell for tap k
   logic [ACC_W-1:0] part_chain [1:TAPS];

   // nothing enters beyond the last tap
   assign part_chain[TAPS] = '0;

   for (genvar k = 1; k < TAPS; k++) begin : g_cell
      firlp_cell #(
         .COEF_W (COEF_W),
         .ACC_W  (ACC_W),
         .COEF   (COEF_W'(firlp_coef(k, COEF_FRAC_BITS)))
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .sample  (req_sample),
         .part_i  (part_chain[k+1]),
         .part_o  (part_chain[k])
      );
   end

   // tap zero, truncation, clamp and result buffering
   firlp_out #(
      .COEF_W         (COEF_W),
      .ACC_W          (ACC_W),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .COEF           (COEF_W'(firlp_coef(0, COEF_FRAC_BITS)))
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .advance   (advance),
      .sample    (req_sample),
      .part_i    (part_chain[1]),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_filtered)
   );

endmodule

`default_nettype wire
